>>> hw/rtl/timestamped_mavlink2_deframer_top_assert.svh
// Assertion macros shared by the deframer RTL.
// Included by files that check their own control logic; needs clk and rst_n in scope.
`ifndef TIMESTAMPED_MAVLINK2_DEFRAMER_TOP_ASSERT_SVH
`define TIMESTAMPED_MAVLINK2_DEFRAMER_TOP_ASSERT_SVH

// Check a property outside reset.
`define MD2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define MD2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/md2_pkg.sv
// Shared constants and types of the timestamped MAVLink v2 deframer.
// No dependencies; imported by all files but the assertion header.
package md2_pkg;

  localparam int unsigned STAMP_BYTES     = 8;
  localparam int unsigned SIGNATURE_BYTES = 13;
  localparam int unsigned HEADER_BYTES    = 9;
  localparam int unsigned CHECKSUM_BYTES  = 2;
  localparam int unsigned FIELD_BYTES     = 6;
  localparam int unsigned ID_BYTES        = 3;

  localparam int unsigned STAMP_W = 8 * STAMP_BYTES;
  localparam int unsigned FIELD_W = 8 * FIELD_BYTES;
  localparam int unsigned ID_W    = 8 * ID_BYTES;
  localparam int unsigned SINCE_W = $clog2(STAMP_BYTES + 1);
  localparam int unsigned HDR_W   = $clog2(HEADER_BYTES + 1);
  localparam int unsigned TRL_W   = $clog2(CHECKSUM_BYTES + SIGNATURE_BYTES + 1);

  localparam logic [7:0] MARKER      = 8'hFD;
  localparam logic [7:0] SIGNED_FLAG = 8'h01;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_TRUNC   = 2'd2;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [1:0]         kind;
    byte_t              payload_byte;
    byte_t              payload_index;
    byte_t              payload_length;
    logic [STAMP_W-1:0] timestamp;
    byte_t              incompat_byte;
    byte_t              compat_byte;
    byte_t              sequence_res;
    byte_t              system_id;
    byte_t              component_id;
    logic [ID_W-1:0]    message_id;
    logic               run_last;
  } md2_result_t;

  // Results of one processed byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0]  count;
    md2_result_t first;
    md2_result_t second;
  } md2_push_t;

endpackage

>>> hw/rtl/md2_in_if.sv
// Byte input channel of the deframer: valid/ready with byte and end flag.
// Depends on md2_pkg for the field types.
interface md2_in_if;
  import md2_pkg::*;

  logic  valid;
  logic  ready;
  byte_t byte_value;
  logic  stream_end;

  modport source(output valid, output byte_value, output stream_end, input ready);
  modport sink(input valid, input byte_value, input stream_end, output ready);
endinterface

>>> hw/rtl/md2_out_if.sv
// Result channel of the deframer: valid/ready with one result record.
// Depends on md2_pkg for the field widths.
interface md2_out_if;
  import md2_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  byte_t              payload_byte;
  byte_t              payload_index;
  byte_t              payload_length;
  logic [STAMP_W-1:0] timestamp;
  byte_t              incompat_byte;
  byte_t              compat_byte;
  byte_t              sequence_res;
  byte_t              system_id;
  byte_t              component_id;
  logic [ID_W-1:0]    message_id;
  logic               run_last;

  modport source(
    output valid, output kind, output payload_byte, output payload_index,
    output payload_length, output timestamp, output incompat_byte, output compat_byte,
    output sequence_res, output system_id, output component_id, output message_id,
    output run_last, input ready
  );
  modport sink(
    input valid, input kind, input payload_byte, input payload_index,
    input payload_length, input timestamp, input incompat_byte, input compat_byte,
    input sequence_res, input system_id, input component_id, input message_id,
    input run_last, output ready
  );
endinterface

>>> hw/rtl/md2_deframe_core.sv
// Input register, frame state and single-pass step logic of the deframer.
// Depends on md2_pkg, md2_in_if and the assertion macro header.
`include "timestamped_mavlink2_deframer_top_assert.svh"

module md2_deframe_core (
  input  logic              clk,
  input  logic              rst_n,
  md2_in_if.sink            in_ch,
  input  logic              fifo_room,
  output md2_pkg::md2_push_t push
);
  import md2_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_TRAILER = 2'd3;

  logic               stg_vld_r, stg_vld_nxt;
  byte_t              stg_byte_r;
  logic               stg_end_r;
  logic               in_fire, step_fire;

  logic [1:0]         phase_r, phase_nxt;
  logic [STAMP_W-1:0] window_r, window_nxt;
  logic [SINCE_W-1:0] since_r, since_nxt;
  logic [HDR_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [FIELD_W-1:0] fields_r, fields_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  byte_t              pay_cnt_r, pay_cnt_nxt;
  logic [TRL_W-1:0]   trl_cnt_r, trl_cnt_nxt;

  logic               emit_a, emit_t;
  md2_result_t        res_a, res_t;
  logic [8:0]         pay_cnt_inc;
  logic [TRL_W-1:0]   trl_need;

  function automatic md2_result_t make_result(
    input logic [1:0]         kind,
    input byte_t              data,
    input byte_t              index,
    input logic [FIELD_W-1:0] fields,
    input logic [STAMP_W-1:0] stamp,
    input logic [ID_W-1:0]    msg_id
  );
    md2_result_t r;
    r.kind           = kind;
    r.payload_byte   = data;
    r.payload_index  = index;
    r.payload_length = fields[7:0];
    r.timestamp      = stamp;
    r.incompat_byte  = fields[15:8];
    r.compat_byte    = fields[23:16];
    r.sequence_res   = fields[31:24];
    r.system_id      = fields[39:32];
    r.component_id   = fields[47:40];
    r.message_id     = msg_id;
    r.run_last       = 1'b0;
    return r;
  endfunction

  // Hold a byte in the input register until the result queue has room for two records.
  assign step_fire   = stg_vld_r && fifo_room;
  assign in_ch.ready = !stg_vld_r || fifo_room;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_fire) begin
      stg_vld_nxt = 1'b1;
    end else if (step_fire) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    window_nxt  = window_r;
    since_nxt   = since_r;
    hdr_cnt_nxt = hdr_cnt_r;
    fields_nxt  = fields_r;
    stamp_nxt   = stamp_r;
    pay_cnt_nxt = pay_cnt_r;
    trl_cnt_nxt = trl_cnt_r;
    emit_a      = 1'b0;
    emit_t      = 1'b0;
    pay_cnt_inc = {1'b0, pay_cnt_r} + 9'd1;
    trl_need    = (fields_r[15:8] & SIGNED_FLAG) != 8'd0
                  ? TRL_W'(CHECKSUM_BYTES + SIGNATURE_BYTES) : TRL_W'(CHECKSUM_BYTES);
    res_a       = make_result(KIND_PAYLOAD, stg_byte_r, pay_cnt_r, fields_r, stamp_r,
                              window_r[ID_W-1:0]);

    case (phase_r)
      PH_HUNT: begin
        if (since_r >= SINCE_W'(STAMP_BYTES) && stg_byte_r == MARKER) begin
          stamp_nxt   = window_r;
          window_nxt  = '0;
          fields_nxt  = '0;
          hdr_cnt_nxt = '0;
          pay_cnt_nxt = '0;
          trl_cnt_nxt = '0;
          phase_nxt   = PH_HEADER;
        end else begin
          window_nxt = {window_r[STAMP_W-9:0], stg_byte_r};
          if (since_r < SINCE_W'(STAMP_BYTES)) begin
            since_nxt = since_r + SINCE_W'(1);
          end
        end
      end
      PH_HEADER: begin
        for (int i = 0; i < FIELD_BYTES; i++) begin
          if (hdr_cnt_r == HDR_W'(i)) begin
            fields_nxt[8*i +: 8] = fields_r[8*i +: 8] | stg_byte_r;
          end
        end
        for (int i = 0; i < ID_BYTES; i++) begin
          if (hdr_cnt_r == HDR_W'(FIELD_BYTES + i)) begin
            window_nxt[8*i +: 8] = window_r[8*i +: 8] | stg_byte_r;
          end
        end
        hdr_cnt_nxt = hdr_cnt_r + HDR_W'(1);
        if (hdr_cnt_nxt >= HDR_W'(HEADER_BYTES)) begin
          phase_nxt = (fields_nxt[7:0] == 8'd0) ? PH_TRAILER : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit_a      = 1'b1;
        pay_cnt_nxt = pay_cnt_inc[7:0];
        if (pay_cnt_inc >= {1'b0, fields_r[7:0]}) begin
          phase_nxt = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        trl_cnt_nxt = trl_cnt_r + TRL_W'(1);
        if (trl_cnt_nxt >= trl_need) begin
          emit_a     = 1'b1;
          res_a      = make_result(KIND_DONE, 8'd0, 8'd0, fields_r, stamp_r,
                                   window_r[ID_W-1:0]);
          phase_nxt  = PH_HUNT;
          window_nxt = '0;
          since_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase

    // Truncated record sees the state as left by this byte.
    res_t = make_result(KIND_TRUNC, 8'd0, 8'd0, fields_nxt, stamp_nxt, window_nxt[ID_W-1:0]);

    // The final byte of a log drops everything back to the reset state.
    if (stg_end_r) begin
      emit_t      = (phase_nxt != PH_HUNT);
      phase_nxt   = PH_HUNT;
      window_nxt  = '0;
      since_nxt   = '0;
      hdr_cnt_nxt = '0;
      fields_nxt  = '0;
      stamp_nxt   = '0;
      pay_cnt_nxt = '0;
      trl_cnt_nxt = '0;
    end

    push.count           = 2'd0;
    push.first           = emit_a ? res_a : res_t;
    push.first.run_last  = !(emit_a && emit_t);
    push.second          = res_t;
    push.second.run_last = 1'b1;
    if (step_fire) begin
      push.count = 2'({1'b0, emit_a} + {1'b0, emit_t});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_byte_r <= in_ch.byte_value;
      stg_end_r  <= in_ch.stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      window_r  <= '0;
      since_r   <= '0;
      hdr_cnt_r <= '0;
      fields_r  <= '0;
      stamp_r   <= '0;
      pay_cnt_r <= '0;
      trl_cnt_r <= '0;
    end else if (step_fire) begin
      phase_r   <= phase_nxt;
      window_r  <= window_nxt;
      since_r   <= since_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      fields_r  <= fields_nxt;
      stamp_r   <= stamp_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      trl_cnt_r <= trl_cnt_nxt;
    end
  end

  `MD2_ASSERT(a_two_only_at_end, push.count == 2'd2 |-> stg_end_r,
              "two records pushed for a byte that does not end the stream")
  `MD2_ASSERT(a_end_resets, (step_fire && stg_end_r) |=> (phase_r == PH_HUNT && since_r == '0),
              "stream end did not return the deframer to hunting")
  `MD2_ASSERT(a_since_sat, since_r <= SINCE_W'(STAMP_BYTES),
              "byte counter since frame end ran past saturation")
  `MD2_ASSERT(a_hdr_bound, phase_r == PH_HEADER |-> hdr_cnt_r < HDR_W'(HEADER_BYTES),
              "header count out of range while collecting header")

endmodule

>>> hw/rtl/md2_result_fifo.sv
// Four-entry result queue: takes up to two records per cycle, delivers one.
// Depends on md2_pkg, md2_out_if and the assertion macro header.
`include "timestamped_mavlink2_deframer_top_assert.svh"

module md2_result_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  md2_pkg::md2_push_t push,
  output logic               fifo_room,
  md2_out_if.source          out_ch
);
  import md2_pkg::*;

  md2_result_t       mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;
  logic [FPTR_W-1:0] wr_ptr_p1;
  logic              pop;
  md2_result_t       head;

  // Room for a worst-case pair of records.
  assign fifo_room = cnt_r <= FCNT_W'(FIFO_DEPTH - 2);
  assign pop       = (cnt_r != '0) && out_ch.ready;
  assign wr_ptr_p1 = wr_ptr_r + FPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FPTR_W'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + FPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + FCNT_W'(push.count) - FCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

  assign head = mem_r[rd_ptr_r];

  assign out_ch.valid          = cnt_r != '0;
  assign out_ch.kind           = head.kind;
  assign out_ch.payload_byte   = head.payload_byte;
  assign out_ch.payload_index  = head.payload_index;
  assign out_ch.payload_length = head.payload_length;
  assign out_ch.timestamp      = head.timestamp;
  assign out_ch.incompat_byte  = head.incompat_byte;
  assign out_ch.compat_byte    = head.compat_byte;
  assign out_ch.sequence_res   = head.sequence_res;
  assign out_ch.system_id      = head.system_id;
  assign out_ch.component_id   = head.component_id;
  assign out_ch.message_id     = head.message_id;
  assign out_ch.run_last       = head.run_last;

  `MD2_ASSERT(a_cnt_bound, cnt_r <= FCNT_W'(FIFO_DEPTH), "result queue overfilled")
  `MD2_ASSERT(a_push_room, push.count != 2'd0 |-> fifo_room,
              "records pushed while the queue lacked room")
  `MD2_ASSERT(a_pop_only, (pop && push.count == 2'd0) |=> cnt_r == $past(cnt_r) - FCNT_W'(1),
              "queue count wrong after a delivery with no push")

endmodule

>>> hw/rtl/timestamped_mavlink2_deframer_top.sv
// Top level of the timestamped MAVLink v2 deframer.
// Depends on md2_pkg, md2_in_if, md2_out_if, md2_deframe_core and md2_result_fifo.
//
//   channel  | interface     | transaction
//   ---------+---------------+---------------------------------------------
//   in_ch    | md2_in_if     | one log byte plus its stream end flag
//   out_ch   | md2_out_if    | one result record: payload byte, frame done
//            |               | or frame truncated, with the frame's header
//
// Flow: one byte per clock while the result queue has room; a byte moves
// from the input register through the step logic into the result queue.
// A byte that ends the stream inside a payload gives two records; the queue
// takes both at once and drains one per clock, so no byte waits while the
// consumer keeps up.
// Reset (rst_n low at a clock edge) clears frame state and empties the queue.
// Stalls: in_ch.ready drops only when the four-entry result queue holds more
// than two records; results already queued are never lost.
module timestamped_mavlink2_deframer_top (
  input  logic      clk,
  input  logic      rst_n,
  md2_in_if.sink    in_ch,
  md2_out_if.source out_ch
);
  import md2_pkg::*;

  md2_push_t push;
  logic      fifo_room;

  // Register the byte, advance the frame state, produce up to two records.
  md2_deframe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_room (fifo_room),
    .push      (push)
  );

  // Hold records until the consumer takes them, one transaction per clock.
  md2_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .fifo_room (fifo_room),
    .out_ch    (out_ch)
  );

endmodule

>>> sim/md2_frame_checker.sv
// Watches the deframer's byte and result channels, predicts every record and compares it.
// Depends on md2_pkg, md2_in_if and md2_out_if; instantiated by tb_timestamped_mavlink2_deframer_top.
module md2_frame_checker (
  input  logic clk,
  input  logic rst_n,
  md2_in_if    in_mon,
  md2_out_if   out_mon,
  output int   fail_count,
  output int   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import md2_pkg::*;

  typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_PAYLOAD, IN_TRAILER} deframe_phase_e;

  deframe_phase_e     phase_q;
  logic [STAMP_W-1:0] window_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [FIELD_W-1:0] fields_q;
  logic [3:0]         since_end_q;
  logic [3:0]         hdr_cnt_q;
  logic [3:0]         trl_cnt_q;
  byte_t              pay_cnt_q;
  md2_result_t        predicted_records[$];
  int                 mismatches;

  task automatic clear_frame_state();
    phase_q     = HUNTING;
    window_q    = '0;
    stamp_q     = '0;
    fields_q    = '0;
    since_end_q = '0;
    hdr_cnt_q   = '0;
    trl_cnt_q   = '0;
    pay_cnt_q   = '0;
  endtask

  function automatic md2_result_t frame_record(logic [1:0] kind, byte_t data, byte_t index);
    md2_result_t r;
    r.kind           = kind;
    r.payload_byte   = data;
    r.payload_index  = index;
    r.payload_length = fields_q[7:0];
    r.timestamp      = stamp_q;
    r.incompat_byte  = fields_q[15:8];
    r.compat_byte    = fields_q[23:16];
    r.sequence_res   = fields_q[31:24];
    r.system_id      = fields_q[39:32];
    r.component_id   = fields_q[47:40];
    // the message id bytes sit in the low end of the window while a frame runs
    r.message_id     = window_q[ID_W-1:0];
    r.run_last       = 1'b0;
    return r;
  endfunction

  // Advance the predicted deframer by one log byte and queue the records it gives.
  task automatic deframe_byte(byte_t b, logic last);
    md2_result_t recs[$];
    byte_t       len;
    int unsigned need;
    len = fields_q[7:0];
    case (phase_q)
      HUNTING: begin
        if (since_end_q >= STAMP_BYTES && b == MARKER) begin
          stamp_q   = window_q;
          window_q  = '0;
          fields_q  = '0;
          hdr_cnt_q = '0;
          pay_cnt_q = '0;
          trl_cnt_q = '0;
          phase_q   = IN_HEADER;
        end else begin
          window_q = {window_q[STAMP_W-9:0], b};
          if (since_end_q < STAMP_BYTES) since_end_q++;
        end
      end
      IN_HEADER: begin
        if (hdr_cnt_q < FIELD_BYTES) fields_q[8*hdr_cnt_q +: 8] = b;
        else if (hdr_cnt_q < HEADER_BYTES) window_q[8*(hdr_cnt_q-FIELD_BYTES) +: 8] = b;
        hdr_cnt_q++;
        if (hdr_cnt_q >= HEADER_BYTES) phase_q = (fields_q[7:0] == 8'd0) ? IN_TRAILER : IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        recs.push_back(frame_record(KIND_PAYLOAD, b, pay_cnt_q));
        pay_cnt_q++;
        if (pay_cnt_q >= len) phase_q = IN_TRAILER;
      end
      default: begin
        need = CHECKSUM_BYTES;
        if ((fields_q[15:8] & SIGNED_FLAG) != 8'd0) need += SIGNATURE_BYTES;
        trl_cnt_q++;
        if (trl_cnt_q >= need) begin
          recs.push_back(frame_record(KIND_DONE, 8'd0, 8'd0));
          phase_q     = HUNTING;
          window_q    = '0;
          since_end_q = '0;
        end
      end
    endcase
    if (last) begin
      if (phase_q != HUNTING) recs.push_back(frame_record(KIND_TRUNC, 8'd0, 8'd0));
      clear_frame_state();
    end
    if (recs.size() > 0) recs[recs.size()-1].run_last = 1'b1;
    foreach (recs[i]) predicted_records.push_back(recs[i]);
  endtask

  function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    md2_result_t want;
    if (!rst_n) begin
      clear_frame_state();
      predicted_records.delete();
      mismatches = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) deframe_byte(in_mon.byte_value, in_mon.stream_end);
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_records.size() == 0) begin
          $error("record with no prediction waiting: kind %0d", out_mon.kind);
          mismatches++;
        end else begin
          want = predicted_records.pop_front();
          mismatches += field_diff("kind", want.kind, out_mon.kind);
          mismatches += field_diff("payload_byte", want.payload_byte, out_mon.payload_byte);
          mismatches += field_diff("payload_index", want.payload_index, out_mon.payload_index);
          mismatches += field_diff("payload_length", want.payload_length,
                                   out_mon.payload_length);
          mismatches += field_diff("timestamp", want.timestamp, out_mon.timestamp);
          mismatches += field_diff("incompat_byte", want.incompat_byte,
                                   out_mon.incompat_byte);
          mismatches += field_diff("compat_byte", want.compat_byte, out_mon.compat_byte);
          mismatches += field_diff("sequence_res", want.sequence_res, out_mon.sequence_res);
          mismatches += field_diff("system_id", want.system_id, out_mon.system_id);
          mismatches += field_diff("component_id", want.component_id, out_mon.component_id);
          mismatches += field_diff("message_id", want.message_id, out_mon.message_id);
          mismatches += field_diff("run_last", want.run_last, out_mon.run_last);
        end
      end
    end
    pending_results <= predicted_records.size();
    fail_count      <= mismatches;
  end

endmodule

>>> sim/tb_timestamped_mavlink2_deframer_top.sv
// Stimulus and verdict for the timestamped MAVLink v2 deframer.
// Depends on md2_pkg, md2_in_if, md2_out_if, md2_frame_checker and the deframer top level.
module tb_timestamped_mavlink2_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import md2_pkg::*;

  // Generous bound: roughly 1000 bytes, each waiting out sender gaps and up to
  // two records behind a receiver that stalls most of the time.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_LONG_FRAMES = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          bytes_sent = 0;
  int          long_frames = 0;
  int          fail_count;
  int          pending_results;

  md2_in_if  in_ch ();
  md2_out_if out_ch ();

  timestamped_mavlink2_deframer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  md2_frame_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #4 clk = ~clk;

  // Abort the run if it hangs, e.g. because predicted records never arrive.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL timestamped_mavlink2_deframer_top");
      $finish;
    end
  end

  // Stall the result channel at random; the rate changes between traffic phases.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one byte, idling first at random, and hold it until the transaction completes.
  task automatic send_byte(input byte_t b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.stream_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Hold the sender off until every predicted record has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Junk between frames: heavy on markers so that early markers turn up, with the
  // odd end of stream while hunting.
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 25) send_byte(MARKER, $urandom_range(99) < 3);
      else send_byte(byte_t'($urandom), $urandom_range(99) < 3);
    end
  endtask

  // One timestamped frame with random content; sometimes cut short by an end of stream,
  // which may land anywhere from the timestamp to the last trailer byte.
  task automatic send_log_frame(input int len);
    byte_t frame_q[$];
    byte_t incompat;
    int    cut;
    int    r;
    incompat = byte_t'($urandom);
    repeat (STAMP_BYTES) frame_q.push_back(byte_t'($urandom));
    frame_q.push_back(MARKER);
    frame_q.push_back(byte_t'(len));
    frame_q.push_back(incompat);
    repeat (HEADER_BYTES - 2) frame_q.push_back(byte_t'($urandom));
    repeat (len) frame_q.push_back(byte_t'($urandom));
    repeat (CHECKSUM_BYTES) frame_q.push_back(byte_t'($urandom));
    if ((incompat & SIGNED_FLAG) != 8'd0)
      repeat (SIGNATURE_BYTES) frame_q.push_back(byte_t'($urandom));
    cut = -1;
    r = $urandom_range(99);
    if (r < 12) cut = $urandom_range(frame_q.size() - 1);
    else if (r < 16) cut = frame_q.size() - 1;
    foreach (frame_q[i]) begin
      send_byte(frame_q[i], i == cut);
      if (i == cut) break;
    end
  endtask

  // Mostly well-formed frames, the rest noise and early markers straight after a frame.
  task automatic run_random_traffic(input int budget);
    int start;
    int r;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_noise($urandom_range(1, 12));
      end else begin
        if (r < 22) send_noise($urandom_range(1, 7));
        if (long_frames < MAX_LONG_FRAMES && $urandom_range(99) < 4) begin
          len = 255;
          long_frames++;
        end else if ($urandom_range(99) < 15) begin
          len = 0;
        end else begin
          len = $urandom_range(1, 24);
        end
        send_log_frame(len);
      end
    end
  endtask

  initial begin
    // Early marker first, then a timestamp of alternating extremes, a marker and an
    // empty-payload unsigned frame whose header bytes swing between 0x00 and 0xFF.
    byte_t directed_bytes[20] = '{
      8'hFD, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
      MARKER,
      8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
      8'h00, 8'hFF
    };
    in_ch.valid      <= 1'b0;
    in_ch.byte_value <= 8'h00;
    in_ch.stream_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b0);
    // end of stream while hunting gives no record
    send_byte(8'hAA, 1'b1);
    drain_results();

    send_idle_pct  = 35;
    recv_stall_pct = 63;
    run_random_traffic(320);
    drain_results();

    send_idle_pct  = 63;
    recv_stall_pct = 35;
    run_random_traffic(320);
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_traffic(320);
    drain_results();

    // let any stray record surface before the verdict
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS timestamped_mavlink2_deframer_top");
    end else begin
      $display("FAIL timestamped_mavlink2_deframer_top");
    end
    $finish;
  end

endmodule
